// ===== rtl/core/ste_pkg.sv =====
`default_nettype none

package ste_pkg;

  localparam int unsigned DEPTH    = 256;
  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned POS_W    = 9;
  localparam int unsigned RND_W    = 15;
  localparam int unsigned BIT_W    = $clog2(RND_W);

  typedef enum logic [1:0] {
    ACT_APPEND  = 2'd0,
    ACT_SHUFFLE = 2'd1,
    ACT_READ    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // RAM read address source
  typedef enum logic [1:0] {
    RSEL_POS,
    RSEL_CURSOR,
    RSEL_SWAP
  } rsel_e;

  // RAM write address/data source
  typedef enum logic [1:0] {
    WSEL_APPEND,
    WSEL_CURSOR,
    WSEL_SWAP
  } wsel_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [ELEM_W-1:0] data_in;
    logic [POS_W-1:0]  position;
    logic [RND_W-1:0]  random_value;
  } ste_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ELEM_W-1:0] read_data;
    logic [CNT_W-1:0]  element_count;
    logic              pass_done;
  } ste_out_t;

  typedef struct packed {
    logic             latch_in;
    logic             append_store;
    logic             reload;
    logic             clear;
    logic             div_init;
    logic             div_step;
    logic [BIT_W-1:0] div_bit;
    logic             ram_re;
    rsel_e            rsel;
    logic             ram_we;
    wsel_e            wsel;
    logic             hold_i;
    logic             cursor_dec;
    logic             res_load;
    status_e          res_status;
    logic             res_done;
    logic             res_rdata;
  } ste_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       full;
    logic       lt2;
    logic       cur_zero;
    logic       cur_ge_cnt;
    logic       cur_one;
    logic       pos_oor;
  } ste_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/shuffle_table_engine_core.sv =====
`default_nettype none

// Table of up to 256 32-bit elements with append, read, clear and one
// Fisher-Yates shuffle step per request. One request is worked on at a time;
// each gives exactly one result. Append, read and clear go from acceptance to
// result through accept, decode/memory access and result load. A shuffle step
// that swaps first forms the bit-serial remainder of the 15-bit random value by
// cursor+1, then does two reads and two writes through the single-port element
// RAM, then the result load. A shuffle step that swaps nothing goes through
// accept, decode and result load only. The result sits in an output
// register, so the next request is accepted while the previous result is
// still stalled; the block holds only when a finished result finds that
// register still occupied. Entries are never cleared; reads and swaps touch
// only entries below the element count.
module shuffle_table_engine_core
  import ste_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire ste_in_t in_req_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output ste_out_t     out_req_o
);

  ste_cmd_t cmd;
  ste_sts_t sts;

  ste_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ste_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_req_o (out_req_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ste_ram.sv =====
`default_nettype none

module ste_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/ste_datapath.sv =====
`default_nettype none

module ste_datapath
  import ste_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire ste_in_t  in_req_i,
  input  wire ste_cmd_t cmd_i,
  output ste_sts_t      sts_o,
  output ste_out_t      out_req_o
);

  ste_in_t            item_q;
  ste_out_t           res_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ADDR_W-1:0]  cursor_q, cursor_d;
  logic [ADDR_W-1:0]  rem_q, rem_d;
  logic [ELEM_W-1:0]  tmp_q;

  logic [CNT_W-1:0]   divisor;
  logic [CNT_W-1:0]   shifted;
  logic [CNT_W-1:0]   diff;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ELEM_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ELEM_W-1:0]  ram_rdata;

  // restoring remainder, one random bit per step, divisor = cursor + 1
  assign divisor = {1'b0, cursor_q} + CNT_W'(1);
  assign shifted = {rem_q, item_q.random_value[cmd_i.div_bit]};
  assign diff    = shifted - divisor;

  always_comb begin
    rem_d = rem_q;
    if (cmd_i.div_init) begin
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d = (shifted >= divisor) ? diff[ADDR_W-1:0] : shifted[ADDR_W-1:0];
    end
  end

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    if (cmd_i.clear) begin
      count_d  = '0;
      cursor_d = '0;
    end else if (cmd_i.append_store) begin
      count_d  = count_q + CNT_W'(1);
      cursor_d = count_q[ADDR_W-1:0];
    end else if (cmd_i.reload) begin
      cursor_d = (count_q == '0) ? '0 : ADDR_W'(count_q - CNT_W'(1));
    end else if (cmd_i.cursor_dec) begin
      cursor_d = cursor_q - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (cmd_i.latch_in) begin
      item_q <= in_req_i;
    end
    if (cmd_i.hold_i) begin
      tmp_q <= ram_rdata;
    end
    if (cmd_i.res_load) begin
      res_q.status        <= cmd_i.res_status;
      res_q.read_data     <= cmd_i.res_rdata ? ram_rdata : '0;
      res_q.element_count <= count_q;
      res_q.pass_done     <= cmd_i.res_done;
    end
  end

  always_comb begin
    ram_we    = cmd_i.ram_we;
    ram_waddr = count_q[ADDR_W-1:0];
    ram_wdata = item_q.data_in;
    case (cmd_i.wsel)
      WSEL_APPEND: begin
        ram_waddr = count_q[ADDR_W-1:0];
        ram_wdata = item_q.data_in;
      end
      WSEL_CURSOR: begin
        ram_waddr = cursor_q;
        ram_wdata = ram_rdata;
      end
      WSEL_SWAP: begin
        ram_waddr = rem_q;
        ram_wdata = tmp_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.rsel)
      RSEL_POS:    ram_raddr = item_q.position[ADDR_W-1:0];
      RSEL_CURSOR: ram_raddr = cursor_q;
      RSEL_SWAP:   ram_raddr = rem_q;
      default:     ram_raddr = cursor_q;
    endcase
  end

  ste_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign sts_o.action     = item_q.action;
  assign sts_o.full       = (count_q >= CNT_W'(DEPTH));
  assign sts_o.lt2        = (count_q < CNT_W'(2));
  assign sts_o.cur_zero   = (cursor_q == '0);
  assign sts_o.cur_ge_cnt = ({1'b0, cursor_q} >= count_q);
  assign sts_o.cur_one    = (cursor_q == ADDR_W'(1));
  assign sts_o.pos_oor    = (item_q.position >= count_q);

  assign out_req_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/ste_ctrl.sv =====
`default_nettype none

module ste_ctrl
  import ste_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire ste_sts_t sts_i,
  output ste_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIVIDE,
    S_RD_I,
    S_RD_J,
    S_WR_I,
    S_WR_J,
    S_FINISH
  } state_e;

  state_e           state_q, state_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  status_e          pend_status_q, pend_status_d;
  logic             pend_done_q, pend_done_d;
  logic             pend_rdata_q, pend_rdata_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    bit_d         = bit_q;
    pend_status_d = pend_status_q;
    pend_done_d   = pend_done_q;
    pend_rdata_d  = pend_rdata_q;

    cmd_o            = '0;
    cmd_o.rsel       = RSEL_POS;
    cmd_o.wsel       = WSEL_APPEND;
    cmd_o.res_status = pend_status_q;
    cmd_o.res_done   = pend_done_q;
    cmd_o.res_rdata  = pend_rdata_q;
    cmd_o.div_bit    = bit_q;

    case (state_q)
      S_IDLE: begin
        cmd_o.latch_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        pend_status_d = ST_OK;
        pend_done_d   = 1'b0;
        pend_rdata_d  = 1'b0;
        state_d       = S_FINISH;
        case (sts_i.action)
          ACT_APPEND: begin
            if (sts_i.full) begin
              cmd_o.reload  = 1'b1;
              pend_status_d = ST_FULL;
            end else begin
              cmd_o.append_store = 1'b1;
              cmd_o.ram_we       = 1'b1;
              cmd_o.wsel         = WSEL_APPEND;
            end
          end
          ACT_READ: begin
            if (sts_i.pos_oor) begin
              pend_status_d = ST_RANGE;
            end else begin
              cmd_o.ram_re = 1'b1;
              cmd_o.rsel   = RSEL_POS;
              pend_rdata_d = 1'b1;
            end
          end
          ACT_SHUFFLE: begin
            if (sts_i.lt2) begin
              pend_done_d = 1'b1;
            end else if (sts_i.cur_zero || sts_i.cur_ge_cnt) begin
              // pass already over: restart from the top
              cmd_o.reload = 1'b1;
              pend_done_d  = 1'b1;
            end else begin
              cmd_o.div_init = 1'b1;
              bit_d          = BIT_W'(RND_W - 1);
              state_d        = S_DIVIDE;
            end
          end
          default: begin
            cmd_o.clear = 1'b1;
          end
        endcase
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (bit_q == '0) begin
          state_d = S_RD_I;
        end else begin
          bit_d = bit_q - BIT_W'(1);
        end
      end
      S_RD_I: begin
        cmd_o.ram_re = 1'b1;
        cmd_o.rsel   = RSEL_CURSOR;
        state_d      = S_RD_J;
      end
      S_RD_J: begin
        cmd_o.ram_re = 1'b1;
        cmd_o.rsel   = RSEL_SWAP;
        cmd_o.hold_i = 1'b1;
        state_d      = S_WR_I;
      end
      S_WR_I: begin
        cmd_o.ram_we = 1'b1;
        cmd_o.wsel   = WSEL_CURSOR;
        state_d      = S_WR_J;
      end
      S_WR_J: begin
        cmd_o.ram_we     = 1'b1;
        cmd_o.wsel       = WSEL_SWAP;
        cmd_o.cursor_dec = 1'b1;
        pend_done_d      = sts_i.cur_one;
        state_d          = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      bit_q         <= '0;
      pend_status_q <= ST_OK;
      pend_done_q   <= 1'b0;
      pend_rdata_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      bit_q         <= bit_d;
      pend_status_q <= pend_status_d;
      pend_done_q   <= pend_done_d;
      pend_rdata_q  <= pend_rdata_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_DECODE))
    else $error("accepted request did not reach decode");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_valid_q || !out_stall_i))
    else $error("result register overwritten while held");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |=> out_valid_o)
    else $error("loaded result not presented");

  a_single_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.ram_we && cmd_o.ram_re))
    else $error("RAM read and write in the same cycle");

endmodule

`default_nettype wire

// ===== tb/shuffle_table_engine_core_test.sv =====
`default_nettype none

module shuffle_table_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ste_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 40;
  localparam int MAX_PRINTED    = 40;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  ste_in_t  in_req;
  logic     out_valid;
  logic     out_stall;
  ste_out_t out_req;

  // table model
  logic [ELEM_W-1:0] model_store [DEPTH];
  int unsigned       model_count;
  int unsigned       model_cursor;

  ste_out_t pending_results [$];
  ste_out_t exp_res;
  int       mismatch_count;
  int       sent_count;
  int       idle_cycles;

  // sender idling
  int gap_max;
  int burst_left;

  // receiver stall pattern and long hold-off
  int stall_pct;
  int stall_run;
  logic stall_level;
  int hold_seq;
  int hold_seen;
  int hold_left;

  shuffle_table_engine_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_req_o   (out_req)
  );

  always #6 clk = ~clk;

  function automatic ste_out_t table_result(input ste_in_t req);
    ste_out_t          res;
    int unsigned       j;
    logic [ELEM_W-1:0] tmp;
    res = '0;
    case (action_e'(req.action))
      ACT_APPEND: begin
        if (model_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          model_store[model_count] = req.data_in;
          model_count++;
        end
        // refused appends reload the cursor too
        model_cursor = (model_count == 0) ? 0 : model_count - 1;
      end
      ACT_SHUFFLE: begin
        if (model_count < 2) begin
          res.pass_done = 1'b1;
        end else if (model_cursor == 0 || model_cursor >= model_count) begin
          res.pass_done = 1'b1;
          model_cursor = model_count - 1;
        end else begin
          j = req.random_value % (model_cursor + 1);
          tmp = model_store[model_cursor];
          model_store[model_cursor] = model_store[j];
          model_store[j] = tmp;
          model_cursor--;
          if (model_cursor == 0) res.pass_done = 1'b1;
        end
      end
      ACT_READ: begin
        if (req.position >= model_count) res.status = ST_RANGE;
        else res.read_data = model_store[req.position];
      end
      ACT_CLEAR: begin
        model_count = 0;
        model_cursor = 0;
      end
    endcase
    res.element_count = CNT_W'(model_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, exp_v, got_v);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input ste_in_t req);
    if (gap_max > 0 && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_results.push_back(table_result(req));
    sent_count++;
    @(negedge clk);
  endtask

  // arg is the data, position or random value, as the action needs
  task automatic issue(input action_e act, input logic [31:0] arg);
    ste_in_t req;
    req.action       = act;
    req.data_in      = $urandom();
    req.position     = POS_W'($urandom());
    req.random_value = RND_W'($urandom());
    case (act)
      ACT_APPEND:  req.data_in = arg;
      ACT_SHUFFLE: req.random_value = arg[RND_W-1:0];
      ACT_READ:    req.position = arg[POS_W-1:0];
      default: ;
    endcase
    send_request(req);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic test_small_table();
    gap_max = 0;
    stall_pct = 0;
    issue(ACT_READ, 0);
    issue(ACT_READ, 511);
    issue(ACT_SHUFFLE, 32'h7FFF);       // empty table
    issue(ACT_APPEND, 32'hFFFF_FFFF);
    issue(ACT_SHUFFLE, 0);              // single entry
    issue(ACT_READ, 0);
    issue(ACT_READ, 1);
    issue(ACT_APPEND, 0);
    issue(ACT_APPEND, 32'hA5A5_5A5A);
    issue(ACT_APPEND, 32'h8000_0001);
    // cursor 3, 2, 1, then pass already finished, then a new pass
    issue(ACT_SHUFFLE, 32'h7FFF);
    issue(ACT_SHUFFLE, 0);
    issue(ACT_SHUFFLE, 32'h4000);
    issue(ACT_SHUFFLE, 5);
    issue(ACT_SHUFFLE, 3);
    for (int p = 0; p < 5; p++) issue(ACT_READ, p);
    issue(ACT_CLEAR, 0);
    issue(ACT_READ, 0);
    issue(ACT_SHUFFLE, 1);
    wait_for_results();
  endtask

  task automatic test_full_table();
    gap_max = 4;
    stall_pct = 20;
    for (int i = 0; i < DEPTH + 2; i++) issue(ACT_APPEND, $urandom());
    for (int i = 0; i < 5; i++) issue(ACT_SHUFFLE, $urandom_range(0, 32767));
    issue(ACT_APPEND, 32'h1234_5678);   // refused, cursor back to the top
    for (int i = 0; i < DEPTH + 1; i++) issue(ACT_SHUFFLE, $urandom_range(0, 32767));
    issue(ACT_READ, 0);
    issue(ACT_READ, DEPTH - 1);
    issue(ACT_READ, DEPTH);
    issue(ACT_READ, 511);
    for (int i = 0; i < 8; i++) issue(ACT_READ, $urandom_range(0, DEPTH - 1));
    issue(ACT_CLEAR, 0);
    wait_for_results();
  endtask

  task automatic test_output_hold();
    gap_max = 0;
    stall_pct = 0;
    hold_seq++;
    for (int i = 0; i < 6; i++) issue(ACT_APPEND, $urandom());
    for (int i = 0; i < 8; i++) issue(ACT_SHUFFLE, $urandom_range(0, 32767));
    for (int i = 0; i < 4; i++) issue(ACT_READ, $urandom_range(0, 7));
    wait_for_results();
  endtask

  task automatic test_random_passes(input int target);
    int n;
    int steps;
    while (sent_count < target) begin
      case ($urandom_range(2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 10;
      endcase
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 80;
      endcase
      if ($urandom_range(99) < 15 || model_count > 200) issue(ACT_CLEAR, 0);
      n = ($urandom_range(99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 40);
      for (int i = 0; i < n; i++) issue(ACT_APPEND, $urandom());
      // usually a full pass plus a step or two past its end
      steps = ($urandom_range(3) == 0) ? $urandom_range(0, model_count)
                                      : model_count + $urandom_range(0, 2);
      for (int i = 0; i < steps; i++) begin
        if ($urandom_range(3) == 0) issue(ACT_SHUFFLE, $urandom_range(0, 7));
        else issue(ACT_SHUFFLE, $urandom_range(0, 32767));
        if ($urandom_range(9) == 0 && model_count > 0)
          issue(ACT_READ, $urandom_range(0, model_count - 1));
      end
      for (int i = $urandom_range(1, 4); i > 0; i--) begin
        if (model_count > 0 && $urandom_range(4) != 0)
          issue(ACT_READ, $urandom_range(0, model_count - 1));
        else
          issue(ACT_READ, $urandom_range(0, 511));
      end
      if ($urandom_range(9) == 0)
        for (int i = $urandom_range(1, 3); i > 0; i--)
          issue(action_e'($urandom_range(3)), $urandom());
      if ($urandom_range(9) == 0) wait_for_results();
    end
  endtask

  always @(negedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_level = ($urandom_range(99) < stall_pct);
        stall_run = $urandom_range(1, 8);
      end
      stall_run--;
      out_stall <= stall_level;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request", 0, out_req.read_data);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_req.status !== exp_res.status)
          report_mismatch("status", 32'(exp_res.status), 32'(out_req.status));
        if (out_req.read_data !== exp_res.read_data)
          report_mismatch("read_data", exp_res.read_data, out_req.read_data);
        if (out_req.element_count !== exp_res.element_count)
          report_mismatch("element_count", 32'(exp_res.element_count),
                          32'(out_req.element_count));
        if (out_req.pass_done !== exp_res.pass_done)
          report_mismatch("pass_done", 32'(exp_res.pass_done), 32'(out_req.pass_done));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    out_stall = 1'b0;
    model_count = 0;
    model_cursor = 0;
    mismatch_count = 0;
    sent_count = 0;
    idle_cycles = 0;
    gap_max = 0;
    burst_left = 0;
    stall_pct = 0;
    stall_run = 0;
    stall_level = 1'b0;
    hold_seq = 0;
    hold_seen = 0;
    hold_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_small_table();
    test_full_table();
    test_output_hold();
    test_random_passes(1450);
    wait_for_results();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/ste_pkg.sv
rtl/core/ste_ram.sv
rtl/core/ste_datapath.sv
rtl/core/ste_ctrl.sv
rtl/core/shuffle_table_engine_core.sv
tb/shuffle_table_engine_core_test.sv
